// ===== rtl/core/ckvt_pkg.sv =====
// Shared types and constants for the command line key/value tokenizer.
// No dependencies.
package ckvt_pkg;

	localparam int MaxResults = 3;
	localparam int CountW     = $clog2(MaxResults + 1);
	localparam int IdxW       = $clog2(MaxResults);

	localparam logic [7:0] CharSpace = 8'h20;
	localparam logic [7:0] CharEqual = 8'h3D;
	localparam logic [7:0] CharQuote = 8'h22;

	typedef enum logic [2:0] {
		KIND_KEY_BYTE   = 3'd0,
		KIND_VALUE_BYTE = 3'd1,
		KIND_KEY_END    = 3'd2,
		KIND_VALUE_END  = 3'd3,
		KIND_LIST_END   = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		PH_SEEK_KEY   = 3'd0,
		PH_KEY        = 3'd1,
		PH_SEEK_VALUE = 3'd2,
		PH_VALUE      = 3'd3,
		PH_QUOTED     = 3'd4
	} phase_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] ch;
		logic       unterm;
		logic       last;
	} result_t;

	typedef struct packed {
		result_t [MaxResults-1:0] entry;
		logic [CountW-1:0]        count;
	} run_t;

	function automatic result_t mk_result(kind_t kind, logic [7:0] ch, logic unterm,
			logic last);
		result_t r;
		r.kind   = kind;
		r.ch     = ((kind == KIND_KEY_BYTE) || (kind == KIND_VALUE_BYTE)) ? ch : 8'h00;
		r.unterm = unterm;
		r.last   = last;
		return r;
	endfunction

endpackage

// ===== rtl/core/ckvt_decode.sv =====
// Next-phase and result-run decode for one byte or end transaction.
// Depends on ckvt_pkg.
module ckvt_decode import ckvt_pkg::*; (
	input  phase_t     phase,
	input  logic [7:0] char_in,
	input  logic       end_of_line,
	output run_t       run,
	output phase_t     next_phase
);

	always_comb begin
		run        = '0;
		next_phase = phase;
		if (end_of_line) begin
			next_phase = PH_SEEK_KEY;
			case (phase)
				PH_KEY: begin
					run.entry[0] = mk_result(KIND_KEY_END, 8'h00, 1'b0, 1'b0);
					run.entry[1] = mk_result(KIND_VALUE_END, 8'h00, 1'b0, 1'b0);
					run.entry[2] = mk_result(KIND_LIST_END, 8'h00, 1'b0, 1'b1);
					run.count    = CountW'(3);
				end
				PH_SEEK_VALUE, PH_VALUE: begin
					run.entry[0] = mk_result(KIND_VALUE_END, 8'h00, 1'b0, 1'b0);
					run.entry[1] = mk_result(KIND_LIST_END, 8'h00, 1'b0, 1'b1);
					run.count    = CountW'(2);
				end
				PH_QUOTED: begin
					run.entry[0] = mk_result(KIND_VALUE_END, 8'h00, 1'b1, 1'b0);
					run.entry[1] = mk_result(KIND_LIST_END, 8'h00, 1'b0, 1'b1);
					run.count    = CountW'(2);
				end
				default: begin
					run.entry[0] = mk_result(KIND_LIST_END, 8'h00, 1'b0, 1'b1);
					run.count    = CountW'(1);
				end
			endcase
		end else begin
			case (phase)
				PH_KEY: begin
					if (char_in == CharSpace) begin
						run.entry[0] = mk_result(KIND_KEY_END, 8'h00, 1'b0, 1'b0);
						run.entry[1] = mk_result(KIND_VALUE_END, 8'h00, 1'b0, 1'b1);
						run.count    = CountW'(2);
						next_phase   = PH_SEEK_KEY;
					end else if (char_in == CharEqual) begin
						run.entry[0] = mk_result(KIND_KEY_END, 8'h00, 1'b0, 1'b1);
						run.count    = CountW'(1);
						next_phase   = PH_SEEK_VALUE;
					end else begin
						run.entry[0] = mk_result(KIND_KEY_BYTE, char_in, 1'b0, 1'b1);
						run.count    = CountW'(1);
					end
				end
				PH_SEEK_VALUE: begin
					if (char_in == CharSpace) begin
						run.entry[0] = mk_result(KIND_VALUE_END, 8'h00, 1'b0, 1'b1);
						run.count    = CountW'(1);
						next_phase   = PH_SEEK_KEY;
					end else if (char_in == CharQuote) begin
						next_phase   = PH_QUOTED;
					end else begin
						run.entry[0] = mk_result(KIND_VALUE_BYTE, char_in, 1'b0, 1'b1);
						run.count    = CountW'(1);
						next_phase   = PH_VALUE;
					end
				end
				PH_VALUE: begin
					if (char_in == CharSpace) begin
						run.entry[0] = mk_result(KIND_VALUE_END, 8'h00, 1'b0, 1'b1);
						run.count    = CountW'(1);
						next_phase   = PH_SEEK_KEY;
					end else begin
						run.entry[0] = mk_result(KIND_VALUE_BYTE, char_in, 1'b0, 1'b1);
						run.count    = CountW'(1);
					end
				end
				PH_QUOTED: begin
					if (char_in == CharQuote) begin
						run.entry[0] = mk_result(KIND_VALUE_END, 8'h00, 1'b0, 1'b1);
						run.count    = CountW'(1);
						next_phase   = PH_SEEK_KEY;
					end else begin
						run.entry[0] = mk_result(KIND_VALUE_BYTE, char_in, 1'b0, 1'b1);
						run.count    = CountW'(1);
					end
				end
				default: begin
					next_phase = PH_SEEK_KEY;
					if (char_in != CharSpace) begin
						run.entry[0] = mk_result(KIND_KEY_BYTE, char_in, 1'b0, 1'b1);
						run.count    = CountW'(1);
						next_phase   = PH_KEY;
					end
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/ckvt_emit.sv =====
// Result register: holds one decoded run and hands it out one transaction at a time.
// Depends on ckvt_pkg.
module ckvt_emit import ckvt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  run_t       run_in,
	output logic       ready,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] token_kind,
	output logic [7:0] char_out,
	output logic       unterminated_quote,
	output logic       last_of_run
);

	logic            valid_q;
	logic [IdxW-1:0] idx_q;
	run_t            run_q;
	result_t         cur;
	logic            take;

	assign cur   = run_q.entry[idx_q];
	assign take  = valid_q && !out_stall;
	assign ready = !valid_q || (take && cur.last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load && ready && (run_in.count != '0)) begin
			valid_q <= 1'b1;
			idx_q   <= '0;
		end else if (take) begin
			if (cur.last) begin
				valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + IdxW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && ready && (run_in.count != '0)) begin
			run_q <= run_in;
		end
	end

	assign out_valid          = valid_q;
	assign token_kind         = cur.kind;
	assign char_out           = cur.ch;
	assign unterminated_quote = cur.unterm;
	assign last_of_run        = cur.last;

`ifndef SYNTHESIS
	a_idx_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (CountW'(idx_q) < run_q.count))
		else $error("result index beyond run length");
	a_idx_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(take && !cur.last) |=> (valid_q && idx_q == $past(idx_q) + IdxW'(1)))
		else $error("run did not advance to next result");
	a_list_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && cur.kind == KIND_LIST_END) |-> cur.last)
		else $error("list end not last of run");
	a_unterm_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && cur.unterm) |-> (cur.kind == KIND_VALUE_END))
		else $error("unterminated quote flag on wrong kind");
`endif

endmodule

// ===== rtl/core/cmdline_key_value_tokenizer.sv =====
// Top level of the command line key/value tokenizer.
// Depends on ckvt_pkg, ckvt_decode and ckvt_emit.
// Takes one byte transaction per cycle, unless stalled, into an input register, decodes it
// against the parse phase and loads the resulting run of zero to three results into the
// result register. A new transaction stalls while the result register still holds results
// of an earlier run, and loads as the last of them is taken. Spaces separate pairs, the
// first '=' ends a key, double quotes enclose a value; an end transaction flushes the open
// token, closes the list and returns to seeking a key.
module cmdline_key_value_tokenizer import ckvt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] char_in,
	input  logic       end_of_line,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] token_kind,
	output logic [7:0] char_out,
	output logic       unterminated_quote,
	output logic       last_of_run
);

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       eol_s1;
	phase_t     phase_q;
	phase_t     next_phase;
	run_t       run;
	logic       emit_ready;
	logic       advance;

	assign advance  = valid_s1 && emit_ready;
	assign in_stall = valid_s1 && !emit_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			phase_q  <= PH_SEEK_KEY;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				phase_q <= next_phase;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			char_s1 <= char_in;
			eol_s1  <= end_of_line;
		end
	end

	ckvt_decode u_decode (
		.phase       (phase_q),
		.char_in     (char_s1),
		.end_of_line (eol_s1),
		.run         (run),
		.next_phase  (next_phase)
	);

	ckvt_emit u_emit (
		.clk                (clk),
		.arst_n             (arst_n),
		.load               (valid_s1),
		.run_in             (run),
		.ready              (emit_ready),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.token_kind         (token_kind),
		.char_out           (char_out),
		.unterminated_quote (unterminated_quote),
		.last_of_run        (last_of_run)
	);

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for cmdline_key_value_tokenizer: directed table, then random command lines
// under varied idling, every result checked in order against a phase-tracking predictor.
// Depends on ckvt_pkg (token kinds, parse phases, character constants) and the RTL only.
`timescale 1ns / 100ps

module tb_top;
	import ckvt_pkg::*;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] ch;
		logic       unterm;
		logic       last;
	} tok_t;

	typedef struct packed {
		logic [1:0]     n;
		tok_t [2:0]     t;
	} tok_run_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       eol;
		logic       typed;
		tok_run_t   run;
	} row_t;

	localparam tok_t T_NONE       = '{KIND_KEY_BYTE, 8'h00, 1'b0, 1'b0};
	localparam tok_t T_LIST_END   = '{KIND_LIST_END, 8'h00, 1'b0, 1'b1};
	localparam tok_t T_KEY_END    = '{KIND_KEY_END, 8'h00, 1'b0, 1'b0};
	localparam tok_t T_KEY_END_L  = '{KIND_KEY_END, 8'h00, 1'b0, 1'b1};
	localparam tok_t T_VAL_END    = '{KIND_VALUE_END, 8'h00, 1'b0, 1'b0};
	localparam tok_t T_VAL_END_L  = '{KIND_VALUE_END, 8'h00, 1'b0, 1'b1};
	localparam tok_t T_VAL_UNTERM = '{KIND_VALUE_END, 8'h00, 1'b1, 1'b0};

	localparam tok_run_t R_NONE      = '{2'd0, '{T_NONE, T_NONE, T_NONE}};
	localparam tok_run_t R_LIST_END  = '{2'd1, '{T_NONE, T_NONE, T_LIST_END}};
	localparam tok_run_t R_KEY_END   = '{2'd1, '{T_NONE, T_NONE, T_KEY_END_L}};
	localparam tok_run_t R_KEY_PAIR  = '{2'd2, '{T_NONE, T_VAL_END_L, T_KEY_END}};
	localparam tok_run_t R_KEY_FLUSH = '{2'd3, '{T_LIST_END, T_VAL_END, T_KEY_END}};
	localparam tok_run_t R_UNTERM    = '{2'd2, '{T_NONE, T_LIST_END, T_VAL_UNTERM}};
	localparam tok_run_t R_KEY_01    =
		'{2'd1, '{T_NONE, T_NONE, '{KIND_KEY_BYTE, 8'h01, 1'b0, 1'b1}}};
	localparam tok_run_t R_KEY_FF    =
		'{2'd1, '{T_NONE, T_NONE, '{KIND_KEY_BYTE, 8'hFF, 1'b0, 1'b1}}};

	localparam int DirRows = 28;

	// typed rows carry their own expectation, the rest go through the predictor
	localparam row_t DirTab [DirRows] = '{
		'{8'hFF,     1'b1, 1'b1, R_LIST_END},
		'{CharSpace, 1'b0, 1'b1, R_NONE},
		'{8'h01,     1'b0, 1'b1, R_KEY_01},
		'{8'hFF,     1'b0, 1'b1, R_KEY_FF},
		'{8'h00,     1'b0, 1'b0, R_NONE},
		'{CharEqual, 1'b0, 1'b1, R_KEY_END},
		'{8'h41,     1'b1, 1'b0, R_NONE},
		'{CharEqual, 1'b0, 1'b0, R_NONE},
		'{CharQuote, 1'b0, 1'b0, R_NONE},
		'{CharSpace, 1'b0, 1'b1, R_KEY_PAIR},
		'{CharQuote, 1'b0, 1'b0, R_NONE},
		'{8'h80,     1'b1, 1'b1, R_KEY_FLUSH},
		'{8'h6B,     1'b0, 1'b0, R_NONE},
		'{CharEqual, 1'b0, 1'b0, R_NONE},
		'{CharSpace, 1'b0, 1'b0, R_NONE},
		'{8'h76,     1'b0, 1'b0, R_NONE},
		'{CharEqual, 1'b0, 1'b0, R_NONE},
		'{8'hFF,     1'b0, 1'b0, R_NONE},
		'{8'h01,     1'b1, 1'b0, R_NONE},
		'{8'h71,     1'b0, 1'b0, R_NONE},
		'{CharEqual, 1'b0, 1'b0, R_NONE},
		'{CharQuote, 1'b0, 1'b1, R_NONE},
		'{CharSpace, 1'b0, 1'b0, R_NONE},
		'{CharQuote, 1'b0, 1'b0, R_NONE},
		'{8'h78,     1'b0, 1'b0, R_NONE},
		'{CharEqual, 1'b0, 1'b0, R_NONE},
		'{CharQuote, 1'b0, 1'b0, R_NONE},
		'{8'hFE,     1'b1, 1'b1, R_UNTERM}
	};

	logic       clk;
	logic       arst_n      = 1'b0;
	logic       in_valid    = 1'b0;
	logic       in_stall;
	logic [7:0] char_in     = 8'h00;
	logic       end_of_line = 1'b0;
	logic       out_valid;
	logic       out_stall   = 1'b0;
	logic [2:0] token_kind;
	logic [7:0] char_out;
	logic       unterminated_quote;
	logic       last_of_run;

	phase_t   line_phase = PH_SEEK_KEY;
	tok_t     due_tokens [$];
	logic     cur_typed  = 1'b0;
	tok_run_t cur_run    = '0;
	int       gap_pct    = 0;
	int       stall_pct  = 0;
	int       items_sent = 0;
	int       faults     = 0;

	cmdline_key_value_tokenizer dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.char_in           (char_in),
		.end_of_line       (end_of_line),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.token_kind        (token_kind),
		.char_out          (char_out),
		.unterminated_quote(unterminated_quote),
		.last_of_run       (last_of_run)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#400000;
		$display("cmdline_key_value_tokenizer verification failed");
		$finish;
	end

	function automatic tok_run_t append_tok(tok_run_t run, kind_t kind, logic [7:0] ch,
			logic unterm);
		tok_t t;
		t.kind   = kind;
		t.ch     = (kind == KIND_KEY_BYTE || kind == KIND_VALUE_BYTE) ? ch : 8'h00;
		t.unterm = unterm;
		t.last   = 1'b0;
		run.t[run.n] = t;
		run.n = run.n + 2'd1;
		return run;
	endfunction

	// advances line_phase and returns the tokens one byte transaction yields
	function automatic tok_run_t tokenize(logic [7:0] ch, logic eol);
		tok_run_t run;
		run = '0;
		if (eol) begin
			case (line_phase)
				PH_KEY: begin
					run = append_tok(run, KIND_KEY_END, 8'h00, 1'b0);
					run = append_tok(run, KIND_VALUE_END, 8'h00, 1'b0);
				end
				PH_SEEK_VALUE, PH_VALUE: run = append_tok(run, KIND_VALUE_END, 8'h00, 1'b0);
				PH_QUOTED: run = append_tok(run, KIND_VALUE_END, 8'h00, 1'b1);
				default: ;
			endcase
			run = append_tok(run, KIND_LIST_END, 8'h00, 1'b0);
			line_phase = PH_SEEK_KEY;
		end else begin
			case (line_phase)
				PH_KEY: begin
					if (ch == CharSpace) begin
						run = append_tok(run, KIND_KEY_END, 8'h00, 1'b0);
						run = append_tok(run, KIND_VALUE_END, 8'h00, 1'b0);
						line_phase = PH_SEEK_KEY;
					end else if (ch == CharEqual) begin
						run = append_tok(run, KIND_KEY_END, 8'h00, 1'b0);
						line_phase = PH_SEEK_VALUE;
					end else begin
						run = append_tok(run, KIND_KEY_BYTE, ch, 1'b0);
					end
				end
				PH_SEEK_VALUE: begin
					if (ch == CharSpace) begin
						run = append_tok(run, KIND_VALUE_END, 8'h00, 1'b0);
						line_phase = PH_SEEK_KEY;
					end else if (ch == CharQuote) begin
						line_phase = PH_QUOTED;
					end else begin
						run = append_tok(run, KIND_VALUE_BYTE, ch, 1'b0);
						line_phase = PH_VALUE;
					end
				end
				PH_VALUE: begin
					if (ch == CharSpace) begin
						run = append_tok(run, KIND_VALUE_END, 8'h00, 1'b0);
						line_phase = PH_SEEK_KEY;
					end else begin
						run = append_tok(run, KIND_VALUE_BYTE, ch, 1'b0);
					end
				end
				PH_QUOTED: begin
					if (ch == CharQuote) begin
						run = append_tok(run, KIND_VALUE_END, 8'h00, 1'b0);
						line_phase = PH_SEEK_KEY;
					end else begin
						run = append_tok(run, KIND_VALUE_BYTE, ch, 1'b0);
					end
				end
				default: begin
					if (ch != CharSpace) begin
						run = append_tok(run, KIND_KEY_BYTE, ch, 1'b0);
						line_phase = PH_KEY;
					end
				end
			endcase
		end
		if (run.n != 2'd0)
			run.t[run.n - 2'd1].last = 1'b1;
		return run;
	endfunction

	// random byte, biased towards the three special characters, minus the ones not allowed
	function automatic logic [7:0] pick_byte(bit sp, bit eq, bit qt);
		logic [7:0] c;
		c = 8'($urandom_range(1, 255));
		case ($urandom_range(0, 11))
			0: c = CharSpace;
			1: c = CharEqual;
			2: c = CharQuote;
			default: ;
		endcase
		while ((c == CharSpace && !sp) || (c == CharEqual && !eq) || (c == CharQuote && !qt))
			c = 8'($urandom_range(1, 255));
		return c;
	endfunction

	always @(negedge clk)
		out_stall <= ($urandom_range(0, 99) < stall_pct);

	always @(posedge clk) begin : monitor
		tok_run_t run;
		tok_t     want;
		if (arst_n) begin
			if (in_valid === 1'b1 && in_stall === 1'b0) begin
				run = tokenize(char_in, end_of_line);
				if (cur_typed)
					run = cur_run;
				for (int i = 0; i < run.n; i++)
					due_tokens.push_back(run.t[i]);
			end
			if (out_valid === 1'b1 && out_stall === 1'b0) begin
				if (due_tokens.size() == 0) begin
					faults++;
					if (faults <= 10)
						$display("%0t: unexpected result kind %0d char %02h", $realtime,
							token_kind, char_out);
				end else begin
					want = due_tokens.pop_front();
					if (token_kind !== want.kind || char_out !== want.ch ||
							unterminated_quote !== want.unterm || last_of_run !== want.last) begin
						faults++;
						if (faults <= 10)
							$display("%0t: want %0d %02h %b %b, got %0d %02h %b %b",
								$realtime, want.kind, want.ch, want.unterm, want.last,
								token_kind, char_out, unterminated_quote, last_of_run);
					end
				end
			end
		end
	end

	task automatic send_item(input logic [7:0] c, input logic eol, input logic typed,
			input tok_run_t run);
		while ($urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		char_in     <= c;
		end_of_line <= eol;
		cur_typed    = typed;
		cur_run      = run;
		in_valid    <= 1'b1;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic send_byte(input logic [7:0] c);
		send_item(c, 1'b0, 1'b0, R_NONE);
	endtask

	// line of key[=value | ="quoted"] pairs, then an end transaction; a quote may be left open
	task automatic send_line();
		int pairs;
		int len;
		bit quoted;
		pairs = $urandom_range(1, 4);
		for (int p = 0; p < pairs; p++) begin
			quoted = 1'b0;
			len = $urandom_range(1, 5);
			send_byte(pick_byte(0, 1, 1));
			for (int i = 1; i < len; i++)
				send_byte(pick_byte(0, 0, 1));
			case ($urandom_range(0, 3))
				0: ;
				1: send_byte(CharEqual);
				2: begin
					send_byte(CharEqual);
					send_byte(pick_byte(0, 1, 0));
					len = $urandom_range(0, 5);
					for (int i = 0; i < len; i++)
						send_byte(pick_byte(0, 1, 1));
				end
				default: begin
					send_byte(CharEqual);
					send_byte(CharQuote);
					len = $urandom_range(0, 6);
					for (int i = 0; i < len; i++)
						send_byte(pick_byte(1, 1, 0));
					if ($urandom_range(0, 9) == 0) begin
						send_item(8'($urandom_range(1, 255)), 1'b1, 1'b0, R_NONE);
						return;
					end
					send_byte(CharQuote);
					quoted = 1'b1;
				end
			endcase
			len = $urandom_range(quoted ? 0 : 1, 2);
			for (int i = 0; i < len; i++)
				send_byte(CharSpace);
		end
		send_item(8'($urandom_range(1, 255)), 1'b1, 1'b0, R_NONE);
	endtask

	task automatic send_noise();
		int len;
		len = $urandom_range(3, 10);
		for (int i = 0; i < len; i++)
			send_item(pick_byte(1, 1, 1), $urandom_range(0, 7) == 0, 1'b0, R_NONE);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (due_tokens.size() != 0);
	endtask

	initial begin : stimulus
		int gap_tab   [4] = '{0, 48, 0, 23};
		int stall_tab [4] = '{0, 0, 48, 23};
		int target;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int r = 0; r < DirRows; r++)
			send_item(DirTab[r].ch, DirTab[r].eol, DirTab[r].typed, DirTab[r].run);
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			gap_pct   = gap_tab[ph];
			stall_pct = stall_tab[ph];
			target    = items_sent + 65;
			while (items_sent < target) begin
				if ($urandom_range(0, 4) == 0)
					send_noise();
				else
					send_line();
			end
			drain();
		end

		repeat (16) @(negedge clk);
		if (due_tokens.size() != 0) begin
			faults++;
			if (faults <= 10)
				$display("%0d expected results never arrived", due_tokens.size());
		end
		if (faults == 0)
			$display("cmdline_key_value_tokenizer verification clean");
		else
			$display("cmdline_key_value_tokenizer verification failed");
		$finish;
	end

endmodule

// ===== cmdline_key_value_tokenizer.f =====
rtl/core/ckvt_pkg.sv
rtl/core/ckvt_decode.sv
rtl/core/ckvt_emit.sv
rtl/core/cmdline_key_value_tokenizer.sv
bench/tb_top.sv
